// ===== sv/qte_pkg.sv =====
// Shared types and constants for the quaternion to Euler angle block.
// No dependencies; imported by every module of the block except qte_checker.
package qte_pkg;

  localparam int QW      = 16;  // input component width
  localparam int MW      = 32;  // product width
  localparam int AW      = 36;  // CORDIC x/y datapath width
  localparam int SW      = 30;  // clamped asin argument width
  localparam int REMW    = 57;  // radicand width
  localparam int ROOTW   = 29;  // square root width
  localparam int ZW      = 25;  // angle accumulator width, Q.20
  localparam int TBL_LEN = 24;
  localparam int FIFO_DEPTH = 4;

  localparam logic signed [AW-1:0] ONE_Q28   = 36'sd268435456;
  localparam logic signed [AW-1:0] M_ONE_Q28 = -36'sd268435456;
  localparam logic [REMW-1:0]      REM_TOP   = {1'b1, 56'b0};
  localparam logic signed [ZW-1:0] ANG_PI    = 25'sd3294199;
  localparam logic signed [15:0]   ROLL_LIM  = 16'sd25736;
  localparam logic signed [15:0]   PITCH_LIM = 16'sd12868;

  typedef struct packed {
    logic signed [MW-1:0] wx;
    logic signed [MW-1:0] yz;
    logic signed [MW-1:0] wz;
    logic signed [MW-1:0] xy;
    logic signed [MW-1:0] xx;
    logic signed [MW-1:0] yy;
    logic signed [MW-1:0] zz;
    logic signed [MW-1:0] wy;
    logic signed [MW-1:0] zx;
  } prod_t;

  typedef struct packed {
    logic signed [AW-1:0] rn;
    logic signed [AW-1:0] rd;
    logic signed [AW-1:0] yn;
    logic signed [AW-1:0] yd;
    logic signed [SW-1:0] s;
    logic                 clamp;
  } bk_pay_t;

  // round(atan(2^-i) * 2^20)
  function automatic logic signed [ZW-1:0] atan_lut(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 25'sd823550;
      1:  v = 25'sd486170;
      2:  v = 25'sd256879;
      3:  v = 25'sd130396;
      4:  v = 25'sd65451;
      5:  v = 25'sd32757;
      6:  v = 25'sd16383;
      7:  v = 25'sd8192;
      8:  v = 25'sd4096;
      9:  v = 25'sd2048;
      10: v = 25'sd1024;
      11: v = 25'sd512;
      12: v = 25'sd256;
      13: v = 25'sd128;
      14: v = 25'sd64;
      15: v = 25'sd32;
      16: v = 25'sd16;
      17: v = 25'sd8;
      18: v = 25'sd4;
      19: v = 25'sd2;
      20: v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/qte_front.sv =====
// Front end: accepts quaternion words and forms the component products the angles need.
// Depends on qte_pkg; pushes into qte_fifo.
module qte_front
  import qte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        q_full,
  output logic        q_push,
  output prod_t       q_din
);

  logic               a_valid_r;
  prod_t              prod_r;
  prod_t              prod_nxt;
  logic signed [QW-1:0] w, x, y, z;

  assign w = in_tdata[15:0];
  assign x = in_tdata[31:16];
  assign y = in_tdata[47:32];
  assign z = in_tdata[63:48];

  always_comb begin
    prod_nxt.wx = w * x;
    prod_nxt.yz = y * z;
    prod_nxt.wz = w * z;
    prod_nxt.xy = x * y;
    prod_nxt.xx = x * x;
    prod_nxt.yy = y * y;
    prod_nxt.zz = z * z;
    prod_nxt.wy = w * y;
    prod_nxt.zx = z * x;
  end

  assign in_tready = !a_valid_r || !q_full;
  assign q_push    = a_valid_r && !q_full;
  assign q_din     = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== sv/qte_fifo.sv =====
// Short queue between front end and back end.
// Depends on qte_pkg for its depth.
module qte_fifo
  import qte_pkg::*;
#(
  parameter int W = 8
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PTRW = $clog2(FIFO_DEPTH);

  logic [W-1:0]    mem_r [FIFO_DEPTH];
  logic [PTRW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTRW:0]   cnt_r;

  assign full  = (cnt_r == (PTRW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

// ===== sv/qte_sqrt.sv =====
// Pipelined floor integer square root, one root bit per stage.
// Depends on qte_pkg; carries a side payload along with each word.
module qte_sqrt
  import qte_pkg::*;
#(
  parameter int PW = 8
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [REMW-1:0]  in_rem,
  input  logic [PW-1:0]    in_pay,
  output logic             out_valid,
  output logic [ROOTW-1:0] out_root,
  output logic [PW-1:0]    out_pay
);

  localparam int TW = REMW + 2;

  logic             v_r    [ROOTW];
  logic [REMW-1:0]  rem_r  [ROOTW];
  logic [ROOTW-1:0] root_r [ROOTW];
  logic [PW-1:0]    pay_r  [ROOTW];

  genvar j;
  generate
    for (j = 0; j < ROOTW; j++) begin : g_stage
      localparam int K = ROOTW - 1 - j;
      logic             pv;
      logic [REMW-1:0]  prem;
      logic [ROOTW-1:0] proot;
      logic [PW-1:0]    ppay;
      logic [TW-1:0]    trial;
      logic             take;

      if (j == 0) begin : g_in
        assign pv    = in_valid;
        assign prem  = in_rem;
        assign proot = '0;
        assign ppay  = in_pay;
      end else begin : g_prev
        assign pv    = v_r[j-1];
        assign prem  = rem_r[j-1];
        assign proot = root_r[j-1];
        assign ppay  = pay_r[j-1];
      end

      assign trial = (TW'(proot) << (K + 1)) | (TW'(1) << (2 * K));
      assign take  = (TW'(prem) >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[j] <= 1'b0;
        end else if (en) begin
          v_r[j] <= pv;
        end
        if (en) begin
          rem_r[j]  <= take ? REMW'(TW'(prem) - trial) : prem;
          root_r[j] <= take ? (proot | (ROOTW'(1) << K)) : proot;
          pay_r[j]  <= ppay;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[ROOTW-1];
  assign out_root  = root_r[ROOTW-1];
  assign out_pay   = pay_r[ROOTW-1];

endmodule

// ===== sv/qte_cordic.sv =====
// Vectoring CORDIC atan2 pipeline: half-plane fold, then one stage per step.
// Depends on qte_pkg for widths and the arctangent constants.
module qte_cordic
  import qte_pkg::*;
#(
  parameter int STEPS = 16
)
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] in_y,
  input  logic signed [AW-1:0] in_x,
  output logic signed [ZW-1:0] out_z
);

  logic signed [AW-1:0] x_r [STEPS+1];
  logic signed [AW-1:0] y_r [STEPS+1];
  logic signed [ZW-1:0] z_r [STEPS+1];
  logic                 zero_r [STEPS+1];

  // fold left half-plane onto the right one
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
        x_r[0] <= -in_x;
        y_r[0] <= -in_y;
        z_r[0] <= (in_y >= 0) ? ANG_PI : -ANG_PI;
      end else begin
        x_r[0] <= in_x;
        y_r[0] <= in_y;
        z_r[0] <= '0;
      end
    end
  end

  genvar g;
  generate
    for (g = 1; g <= STEPS; g++) begin : g_step
      logic signed [AW-1:0] xs, ys;
      assign xs = x_r[g-1] >>> (g - 1);
      assign ys = y_r[g-1] >>> (g - 1);
      always_ff @(posedge clk) begin
        if (en) begin
          zero_r[g] <= zero_r[g-1];
          if (y_r[g-1] > 0) begin
            x_r[g] <= x_r[g-1] + ys;
            y_r[g] <= y_r[g-1] - xs;
            z_r[g] <= z_r[g-1] + atan_lut(g - 1);
          end else begin
            x_r[g] <= x_r[g-1] - ys;
            y_r[g] <= y_r[g-1] + xs;
            z_r[g] <= z_r[g-1] - atan_lut(g - 1);
          end
        end
      end
    end
  endgenerate

  assign out_z = zero_r[STEPS] ? '0 : z_r[STEPS];

endmodule

// ===== sv/quaternion_to_euler_angles.sv =====
// Quaternion (Q1.14) to roll/pitch/yaw (Q3.13), Z-Y-X order.
// Depends on qte_pkg, qte_front, qte_fifo, qte_sqrt, qte_cordic.
//
//  channel | dir | tdata fields (low bit up)                 | tuser
//  in_     | in  | quat_w, quat_x, quat_y, quat_z (16b each) | -
//  out_    | out | roll_angle 16b, pitch_angle 15b, yaw 16b  | pitch_clamped
//
// One word per cycle sustained while the output is not stalled; the back end is fully pipelined.
// Path: product register, queue, b0, b1, square root (one bit per stage), CORDIC fold and steps, output register.
// rst_n synchronous, clears all valid flags and queue pointers.
// A stalled output freezes the back end; the 4-entry queue keeps taking input until it is full.
module quaternion_to_euler_angles
  import qte_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // roll_angle, pitch_angle, yaw_angle, pad
  output logic        out_tuser   // pitch_clamped
);

  localparam int PW = $bits(bk_pay_t);

  logic  q_push, q_full, q_pop, q_empty;
  prod_t q_din, q_dout;
  logic  en;

  qte_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_full, .q_push, .q_din
  );

  qte_fifo #(.W($bits(prod_t))) u_fifo (
    .clk, .rst_n, .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  logic out_valid_r;
  assign en    = !out_valid_r || out_tready;
  assign q_pop = en && !q_empty;

  // stage b0: sums, asin argument clamp
  bk_pay_t              b0_r, b0_nxt;
  logic                 b0_valid_r;
  logic signed [AW-1:0] s_full;

  always_comb begin
    b0_nxt.rn = (AW'(q_dout.wx) + AW'(q_dout.yz)) <<< 1;
    b0_nxt.rd = ONE_Q28 - ((AW'(q_dout.xx) + AW'(q_dout.yy)) <<< 1);
    b0_nxt.yn = (AW'(q_dout.wz) + AW'(q_dout.xy)) <<< 1;
    b0_nxt.yd = ONE_Q28 - ((AW'(q_dout.yy) + AW'(q_dout.zz)) <<< 1);
    s_full    = (AW'(q_dout.wy) - AW'(q_dout.zx)) <<< 1;
    if (s_full > ONE_Q28) begin
      b0_nxt.s     = SW'(ONE_Q28);
      b0_nxt.clamp = 1'b1;
    end else if (s_full < M_ONE_Q28) begin
      b0_nxt.s     = SW'(M_ONE_Q28);
      b0_nxt.clamp = 1'b1;
    end else begin
      b0_nxt.s     = SW'(s_full);
      b0_nxt.clamp = 1'b0;
    end
  end

  // stage b1: radicand 1 - s^2 in Q.56
  bk_pay_t           b1_r;
  logic              b1_valid_r;
  logic [REMW-1:0]   b1_rem_r;
  logic signed [2*SW-1:0] sq;

  assign sq = b0_r.s * b0_r.s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_valid_r <= 1'b0;
      b1_valid_r <= 1'b0;
    end else if (en) begin
      b0_valid_r <= !q_empty;
      b1_valid_r <= b0_valid_r;
    end
    if (en) begin
      b0_r     <= b0_nxt;
      b1_r     <= b0_r;
      b1_rem_r <= REM_TOP - sq[REMW-1:0];
    end
  end

  logic             sq_valid;
  logic [ROOTW-1:0] sq_root;
  logic [PW-1:0]    sq_pay_bits;
  bk_pay_t          sq_pay;

  qte_sqrt #(.PW(PW)) u_sqrt (
    .clk, .rst_n, .en,
    .in_valid(b1_valid_r), .in_rem(b1_rem_r), .in_pay(b1_r),
    .out_valid(sq_valid), .out_root(sq_root), .out_pay(sq_pay_bits)
  );

  assign sq_pay = sq_pay_bits;

  logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk, .en, .in_y(sq_pay.rn), .in_x(sq_pay.rd), .out_z(roll_z)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk, .en, .in_y(AW'(sq_pay.s)), .in_x(AW'(sq_root)), .out_z(pitch_z)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk, .en, .in_y(sq_pay.yn), .in_x(sq_pay.yd), .out_z(yaw_z)
  );

  // valid and clamp flag ride alongside the CORDIC stages
  logic dl_valid_r [CORDIC_STEPS+1];
  logic dl_clamp_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) dl_valid_r[i] <= 1'b0;
    end else if (en) begin
      dl_valid_r[0] <= sq_valid;
      for (int i = 1; i <= CORDIC_STEPS; i++) dl_valid_r[i] <= dl_valid_r[i-1];
    end
    if (en) begin
      dl_clamp_r[0] <= sq_pay.clamp;
      for (int i = 1; i <= CORDIC_STEPS; i++) dl_clamp_r[i] <= dl_clamp_r[i-1];
    end
  end

  // Q.20 -> Q3.13, round half up, saturate
  function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] z,
                                                input logic signed [15:0] lim);
    logic signed [ZW:0]   t;
    logic signed [ZW-7:0] r;
    t = (ZW+1)'(z) + (ZW+1)'(64);
    r = t[ZW:7];
    if (r > lim) return lim;
    else if (r < -lim) return -lim;
    else return 16'(r);
  endfunction

  logic signed [15:0] roll_r, yaw_r, pitch_w;
  logic signed [14:0] pitch_r;
  logic               clamp_r;

  assign pitch_w = to_q13(pitch_z, PITCH_LIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dl_valid_r[CORDIC_STEPS];
    end
    if (en) begin
      roll_r  <= to_q13(roll_z, ROLL_LIM);
      pitch_r <= pitch_w[14:0];
      yaw_r   <= to_q13(yaw_z, ROLL_LIM);
      clamp_r <= dl_clamp_r[CORDIC_STEPS];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, yaw_r, pitch_r, roll_r};
  assign out_tuser  = clamp_r;

endmodule

// ===== sv/qte_checker.sv =====
// Port-level checks for the quaternion to Euler angle block.
// Bound to quaternion_to_euler_angles; no package dependency.
module qte_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  logic signed [15:0] roll, yaw;
  logic signed [14:0] pitch;

  assign roll  = out_tdata[15:0];
  assign pitch = out_tdata[30:16];
  assign yaw   = out_tdata[46:31];

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pitch <= 15'sd12868) && (pitch >= -15'sd12868))
    else $error("pitch out of range");

  a_roll_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (roll <= 16'sd25736) && (roll >= -16'sd25736) &&
                   (yaw <= 16'sd25736) && (yaw >= -16'sd25736) && !out_tdata[47])
    else $error("roll or yaw out of range, or pad bit set");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);

// ===== tb/sv/tb.sv =====
// Self-checking bench for quaternion_to_euler_angles: drives quaternions over the
// in_ stream, predicts roll/pitch/yaw/clamp per word and checks every out_ word.
// Depends on qte_pkg and the block's RTL.
module tb;
  import qte_pkg::*;

  localparam int STEPS = 16;
  localparam longint PI_Q20 = 3294199;
  localparam longint UNIT_Q28 = 64'sd1 << 28;
  localparam longint LIM_ROLL = 25736;
  localparam longint LIM_PITCH = 12868;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;
  localparam longint ATAN_Q20 [0:23] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

  typedef struct {
    logic [15:0] roll;
    logic [14:0] pitch;
    logic [15:0] yaw;
    logic        clamp;
  } euler_t;

  class euler_board;
    euler_t angles_due[$];
    int errors = 0;

    static function longint unsigned root_floor(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    static function longint vec_angle(longint y, longint x);
      longint z = 0;
      longint xs, ys;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? PI_Q20 : -PI_Q20;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += ATAN_Q20[i];
        end else begin
          x -= ys; y += xs; z -= ATAN_Q20[i];
        end
      end
      return z;
    endfunction

    static function longint round_sat(longint z, longint lim);
      longint r = (z + 64) >>> 7;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
    endfunction

    function void note_quat(logic [63:0] word);
      longint w, x, y, z, rn, rd, yn, yd, s, c;
      euler_t e;
      w = longint'($signed(word[15:0]));
      x = longint'($signed(word[31:16]));
      y = longint'($signed(word[47:32]));
      z = longint'($signed(word[63:48]));
      rn = 2 * (w * x + y * z);
      rd = UNIT_Q28 - 2 * (x * x + y * y);
      yn = 2 * (w * z + x * y);
      yd = UNIT_Q28 - 2 * (y * y + z * z);
      s = 2 * (w * y - z * x);
      e.clamp = 1'b0;
      if (s > UNIT_Q28) begin
        s = UNIT_Q28; e.clamp = 1'b1;
      end else if (s < -UNIT_Q28) begin
        s = -UNIT_Q28; e.clamp = 1'b1;
      end
      c = longint'(root_floor((64'd1 << 56) - longint'(s * s)));
      e.roll = 16'(round_sat(vec_angle(rn, rd), LIM_ROLL));
      e.pitch = 15'(round_sat(vec_angle(s, c), LIM_PITCH));
      e.yaw = 16'(round_sat(vec_angle(yn, yd), LIM_ROLL));
      angles_due = {angles_due, e};
    endfunction

    function void check_angles(logic [47:0] word, logic flag);
      euler_t e;
      if (angles_due.size() == 0) begin
        $error("unexpected output word %h", word);
        errors++;
        return;
      end
      e = angles_due.pop_front();
      if (word[15:0] !== e.roll) begin
        $error("roll_angle exp %h got %h", e.roll, word[15:0]); errors++;
      end
      if (word[30:16] !== e.pitch) begin
        $error("pitch_angle exp %h got %h", e.pitch, word[30:16]); errors++;
      end
      if (word[46:31] !== e.yaw) begin
        $error("yaw_angle exp %h got %h", e.yaw, word[46:31]); errors++;
      end
      if (flag !== e.clamp) begin
        $error("pitch_clamped exp %b got %b", e.clamp, flag); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;

  euler_board sb = new();
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  hold_req = 0;
  bit  steady = 0;

  quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_quat(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_angles(out_tdata, out_tuser);
  end

  // receiver: long hold-off on request, always ready in steady mode, otherwise random back-pressure
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 19);
    end
  end

  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    if (!steady && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x, w};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_unit_quat();
    real a, b, c, d, n;
    a = real'(int'($urandom_range(65535)) - 32768);
    b = real'(int'($urandom_range(65535)) - 32768);
    c = real'(int'($urandom_range(65535)) - 32768);
    d = real'(int'($urandom_range(65535)) - 32768);
    if ($urandom_range(9) == 0) begin
      c = a; b = b / 64.0; d = d / 64.0;   // near gimbal lock
    end
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) n = 1.0;
    send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
              16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 85) send_unit_quat();
      else send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.angles_due.size() != 0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // identity, negated, half turns about each axis
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, -16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(0, 0, 0, -16384);
    // gimbal lock both ways, slightly over unit so the asin clamps, then a non-unit quaternion
    send_quat(11586, 0, 11586, 0);
    send_quat(11586, 0, -11586, 0);
    send_quat(0, 11586, 0, 11586);
    send_quat(16384, 16384, 16384, 16384);
    // atan2 of the zero vector
    send_quat(0, 8192, 8192, 0);
    // y negative with x negative: lands near -pi
    send_quat(-100, 16384, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_random(120);
    steady = 1;
    send_random(60);
    steady = 0;
    hold_req = 1;            // receiver stalls while we keep offering words
    send_random(60);
    wait_drained();          // sender pause until all results are back
    send_random(160);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.angles_due.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== quaternion_to_euler_angles.f =====
sv/qte_pkg.sv
sv/qte_front.sv
sv/qte_fifo.sv
sv/qte_sqrt.sv
sv/qte_cordic.sv
sv/quaternion_to_euler_angles.sv
sv/qte_checker.sv
tb/sv/tb.sv
